@@ hw/rtl/unique_entry_fifo_defines.svh @@
// Assertion macros shared by the checker.
`ifndef UNIQUE_ENTRY_FIFO_DEFINES_SVH
`define UNIQUE_ENTRY_FIFO_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define UEF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define UEF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ufifo_pkg.sv @@
package ufifo_pkg;

    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 6;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 3;
    localparam int CAP_W    = 7;
    localparam int COUNT_W  = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // request kinds
    localparam logic [1:0] REQ_ENQ  = 2'd0;
    localparam logic [1:0] REQ_DEQ  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE = 3'd4;

    // broadcast to every cell
    typedef struct packed {
        logic search;   // accumulate match of key against stored entries
        logic rd;       // pick up entry at rd_idx
        logic shift;    // every entry moves one place toward the head
        logic load;     // cell at the fill position takes the key
    } ufifo_cmd_t;

endpackage

@@ hw/rtl/ufifo_cell.sv @@
module ufifo_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CMP_W      = 7,
    parameter int IDX        = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ufifo_pkg::ufifo_cmd_t  cmd,
    input  logic [DATA_WIDTH-1:0]  key,
    input  logic [CMP_W-1:0]       fill,
    input  logic [CMP_W-1:0]       rd_idx,
    input  logic [DATA_WIDTH-1:0]  next_entry,
    input  logic                   hit_in,
    input  logic [DATA_WIDTH-1:0]  data_in,
    output logic                   hit_out,
    output logic [DATA_WIDTH-1:0]  data_out,
    output logic [DATA_WIDTH-1:0]  entry
);

    localparam logic [CMP_W-1:0] POS = CMP_W'(IDX);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    logic                  hit_reg;
    logic                  hit_next;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  occupied;

    assign occupied = POS < fill;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.shift)
        begin
            entry_next = next_entry;
        end
        else if (cmd.load && POS == fill)
        begin
            entry_next = key;
        end
    end

    // probe stage: match and read data ripple one cell per cycle
    assign hit_next  = hit_in | (cmd.search & occupied & (entry_reg == key));
    assign data_next = (cmd.rd && occupied && POS == rd_idx) ? entry_reg : data_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        data_reg  <= data_next;
    end

    assign hit_out  = hit_reg;
    assign data_out = data_reg;
    assign entry    = entry_reg;

endmodule

@@ hw/rtl/unique_entry_fifo.sv @@
// Each request is registered, then the match/read probe walks the cell chain one cell
// per clock, and the update and result commit after it leaves the last cell.
// A new request is taken only after the previous one has committed.
// A result waiting on the output does not block the next input beat.
// Reset: count cleared, capacity_limit set to 64, output empty; entries keep junk.
module unique_entry_fifo #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value[31:0], index[37:32], zero pad
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // item_out[31:0], status[34:32], count[41:35], pad
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data     // capacity_limit
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > ufifo_pkg::CAP_W) ? CNT_W : ufifo_pkg::CAP_W;

    logic                           busy_reg;
    logic [CNT_W-1:0]               run_reg;
    logic [1:0]                     req_reg;
    logic [DATA_WIDTH-1:0]          key_reg;
    logic [ufifo_pkg::INDEX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [CNT_W-1:0]               cnt_next;
    logic [ufifo_pkg::CAP_W-1:0]    cap_reg;
    logic                           out_valid_reg;
    logic [ufifo_pkg::ITEM_W-1:0]   out_item_reg;
    logic [ufifo_pkg::STATUS_W-1:0] out_status_reg;
    logic [ufifo_pkg::COUNT_W-1:0]  out_count_reg;

    logic                           in_beat;
    logic                           finish;
    logic                           commit;
    logic [CMP_W-1:0]               cnt_cmp;
    logic [CMP_W-1:0]               idx_cmp;
    logic [CMP_W-1:0]               cap_cmp;
    logic [CMP_W-1:0]               eff_cap;
    logic [ufifo_pkg::STATUS_W-1:0] st;
    logic [ufifo_pkg::ITEM_W-1:0]   item;
    ufifo_pkg::ufifo_cmd_t          cmd;

    logic [DATA_WIDTH-1:0] entry_w [DEPTH];
    logic [DATA_WIDTH-1:0] data_w  [DEPTH];
    logic                  hit_w   [DEPTH];

    assign s_axis_tready = !busy_reg;
    assign in_beat       = s_axis_tvalid && !busy_reg;
    assign finish        = busy_reg && (run_reg == CNT_W'(DEPTH));
    assign commit        = finish && (!out_valid_reg || m_axis_tready);

    assign cnt_cmp = CMP_W'(cnt_reg);
    assign idx_cmp = CMP_W'(idx_reg);
    assign cap_cmp = CMP_W'(cap_reg);
    assign eff_cap = (cap_cmp > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_cmp;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] nxt;
            logic                  hin;
            logic [DATA_WIDTH-1:0] din;

            if (g == 0)
            begin : g_head
                assign hin = 1'b0;
                assign din = '0;
            end
            else
            begin : g_body
                assign hin = hit_w[g-1];
                assign din = data_w[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_tail
                assign nxt = entry_w[g];
            end
            else
            begin : g_mid
                assign nxt = entry_w[g+1];
            end

            ufifo_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .CMP_W      (CMP_W),
                .IDX        (g)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .key        (key_reg),
                .fill       (cnt_cmp),
                .rd_idx     (idx_cmp),
                .next_entry (nxt),
                .hit_in     (hin),
                .data_in    (din),
                .hit_out    (hit_w[g]),
                .data_out   (data_w[g]),
                .entry      (entry_w[g])
            );
        end
    endgenerate

    // decision once the probe has left the last cell
    always_comb
    begin
        st         = ufifo_pkg::ST_OK;
        item       = '0;
        cnt_next   = cnt_reg;
        cmd.search = (req_reg == ufifo_pkg::REQ_ENQ);
        cmd.rd     = (req_reg == ufifo_pkg::REQ_READ);
        cmd.shift  = 1'b0;
        cmd.load   = 1'b0;
        case (req_reg)
            ufifo_pkg::REQ_ENQ:
            begin
                if (hit_w[DEPTH-1])
                begin
                    st = ufifo_pkg::ST_DUP;
                end
                else if (cnt_cmp >= eff_cap)
                begin
                    st = ufifo_pkg::ST_FULL;
                end
                else
                begin
                    cmd.load = commit;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ufifo_pkg::REQ_DEQ:
            begin
                if (cnt_reg == '0)
                begin
                    st = ufifo_pkg::ST_EMPTY;
                end
                else
                begin
                    item      = ufifo_pkg::ITEM_W'(entry_w[0]);
                    cmd.shift = commit;
                    cnt_next  = cnt_reg - CNT_W'(1);
                end
            end
            ufifo_pkg::REQ_READ:
            begin
                if (idx_cmp >= cnt_cmp)
                begin
                    st = ufifo_pkg::ST_RANGE;
                end
                else
                begin
                    item = ufifo_pkg::ITEM_W'(data_w[DEPTH-1]);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            run_reg       <= '0;
            cnt_reg       <= '0;
            cap_reg       <= ufifo_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (in_beat)
            begin
                busy_reg <= 1'b1;
                run_reg  <= '0;
            end
            else if (commit)
            begin
                busy_reg <= 1'b0;
            end
            else if (busy_reg && !finish)
            begin
                run_reg <= run_reg + CNT_W'(1);
            end
            if (commit)
            begin
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            req_reg <= s_axis_tuser;
            key_reg <= DATA_WIDTH'(s_axis_tdata[31:0]);
            idx_reg <= s_axis_tdata[37:32];
        end
        if (commit)
        begin
            out_item_reg   <= item;
            out_status_reg <= st;
            out_count_reg  <= ufifo_pkg::COUNT_W'(cnt_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_count_reg, out_status_reg, out_item_reg};

endmodule

@@ hw/rtl/ufifo_checker.sv @@
`include "unique_entry_fifo_defines.svh"

module ufifo_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        cfg_wr_en,
    input logic [6:0]  cfg_wr_data
);

    logic [31:0] item;
    logic [2:0]  status;
    logic [6:0]  count;

    assign item   = m_axis_tdata[31:0];
    assign status = m_axis_tdata[34:32];
    assign count  = m_axis_tdata[41:35];

    `UEF_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")

    `UEF_ASSERT_NXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken while one is in flight")

    `UEF_ASSERT_IMP(a_empty_result, m_axis_tvalid && status == ufifo_pkg::ST_EMPTY, item == 32'd0 && count == 7'd0, "empty result with data or nonzero count")

    `UEF_ASSERT_IMP(a_reject_no_item, m_axis_tvalid && (status == ufifo_pkg::ST_DUP || status == ufifo_pkg::ST_FULL || status == ufifo_pkg::ST_RANGE), item == 32'd0, "rejected request returned an item")

endmodule

bind unique_entry_fifo ufifo_checker u_ufifo_checker (.*);

@@ tb/tb_unique_entry_fifo.sv @@
module tb_unique_entry_fifo;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = 64;
    localparam int SETTLE_CYCLES  = 2 * (DEPTH + 2);
    localparam int CYCLE_LIMIT    = 1500000;
    localparam int HOLD_CYCLES    = 1500;
    localparam int PHASE_ITEMS    = 125;
    localparam int POOL_SIZE      = 96;

    // request code the block must ignore
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [ufifo_pkg::ITEM_W-1:0]   item;
        logic [ufifo_pkg::STATUS_W-1:0] status;
        logic [ufifo_pkg::COUNT_W-1:0]  count;
    } fifo_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;     // value[31:0], index[37:32], zero pad
    logic [1:0]  s_axis_tuser = '0;     // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // item_out[31:0], status[34:32], count[41:35], pad
    logic        cfg_wr_en = 1'b0;
    logic [6:0]  cfg_wr_data = '0;      // capacity_limit

    // shadow of the block's storage and register
    logic [ufifo_pkg::VALUE_W-1:0] shadow_entries[$];
    int unsigned        shadow_capacity = 32'(ufifo_pkg::CAP_RESET);

    fifo_reply_t pending_replies[$];

    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned requests_sent = 0;
    int unsigned replies_checked = 0;
    int unsigned status_seen[5] = '{default: 0};

    // source / sink pacing
    bit          src_hot = 1'b0;
    bit          src_gaps_on = 1'b1;
    bit          sink_gaps_on = 1'b1;
    int unsigned next_gap = 0;
    realtime     src_drop_at = -1.0;
    int unsigned sink_hold_req = 0;
    int unsigned sink_left = 0;

    unique_entry_fifo u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_replies.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 20);
        else
            return $urandom_range(40, 160);
    endfunction

    // next state of the dedup queue and the reply for one request
    function automatic fifo_reply_t apply_request(input logic [1:0] kind,
                                                  input logic [ufifo_pkg::VALUE_W-1:0] val,
                                                  input logic [ufifo_pkg::INDEX_W-1:0] idx);
        fifo_reply_t reply;
        int unsigned eff_cap;
        bit          hit;
        reply = '{item: '0, status: ufifo_pkg::ST_OK, count: '0};
        eff_cap = (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
        hit = 1'b0;
        case (kind)
            ufifo_pkg::REQ_ENQ:
            begin
                foreach (shadow_entries[i])
                    if (shadow_entries[i] == val)
                        hit = 1'b1;
                if (hit)
                    reply.status = ufifo_pkg::ST_DUP;
                else if (shadow_entries.size() >= eff_cap)
                    reply.status = ufifo_pkg::ST_FULL;
                else
                    shadow_entries.push_back(val);
            end
            ufifo_pkg::REQ_DEQ:
            begin
                if (shadow_entries.size() == 0)
                    reply.status = ufifo_pkg::ST_EMPTY;
                else
                    reply.item = shadow_entries.pop_front();
            end
            ufifo_pkg::REQ_READ:
            begin
                if (idx >= shadow_entries.size())
                    reply.status = ufifo_pkg::ST_RANGE;
                else
                    reply.item = shadow_entries[idx];
            end
            default: ;
        endcase
        reply.count = ufifo_pkg::COUNT_W'(shadow_entries.size());
        return reply;
    endfunction

    // one input beat; valid stays up when the following beat comes back to back
    task automatic send_req(input logic [1:0] kind,
                            input logic [ufifo_pkg::VALUE_W-1:0] val,
                            input logic [ufifo_pkg::INDEX_W-1:0] idx);
        if (!src_hot)
        begin
            repeat (next_gap) @(posedge clk);
            if ($realtime == src_drop_at)
                @(posedge clk);
            s_axis_tvalid <= 1'b1;
            src_hot = 1'b1;
        end
        s_axis_tdata <= {2'b00, idx, val};
        s_axis_tuser <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_replies.push_back(apply_request(kind, val, idx));
        requests_sent++;
        next_gap = src_gaps_on ? pick_gap() : 0;
        if (next_gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            src_hot = 1'b0;
            src_drop_at = $realtime;
        end
    endtask

    task automatic src_release();
        if (src_hot)
        begin
            s_axis_tvalid <= 1'b0;
            src_hot = 1'b0;
            src_drop_at = $realtime;
        end
        next_gap = 0;
    endtask

    task automatic wait_all_replies();
        src_release();
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [6:0] cap);
        wait_all_replies();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        shadow_capacity = 32'(cap);
        @(posedge clk);
    endtask

    // biased toward filling or draining; values often repeat to provoke duplicates
    task automatic send_random_req(input bit fill_bias,
                                   const ref logic [ufifo_pkg::VALUE_W-1:0] pool[]);
        int unsigned                   r;
        logic [1:0]                    kind;
        logic [ufifo_pkg::VALUE_W-1:0] val;
        logic [ufifo_pkg::INDEX_W-1:0] idx;
        r = $urandom_range(0, 99);
        if (r < 1)
            kind = REQ_UNUSED;
        else if (r < (fill_bias ? 60 : 25))
            kind = ufifo_pkg::REQ_ENQ;
        else if (r < (fill_bias ? 75 : 70))
            kind = ufifo_pkg::REQ_DEQ;
        else
            kind = ufifo_pkg::REQ_READ;
        r = $urandom_range(0, 99);
        if (r < 20 && shadow_entries.size() != 0)
            val = shadow_entries[$urandom_range(0, shadow_entries.size() - 1)];
        else if (r < 65)
            val = pool[$urandom_range(0, pool.size() - 1)];
        else
            val = $urandom;
        if (shadow_entries.size() != 0 && $urandom_range(0, 99) < 75)
            idx = ufifo_pkg::INDEX_W'($urandom_range(0, shadow_entries.size() - 1));
        else
            idx = ufifo_pkg::INDEX_W'($urandom_range(0, DEPTH - 1));
        send_req(kind, val, idx);
    endtask

    task automatic test_directed_basics();
        send_req(ufifo_pkg::REQ_DEQ, 32'h0, 6'd0);             // empty queue
        send_req(ufifo_pkg::REQ_READ, 32'h0, 6'd0);            // nothing stored
        send_req(ufifo_pkg::REQ_ENQ, 32'h0000_0000, 6'd0);
        send_req(ufifo_pkg::REQ_ENQ, 32'hFFFF_FFFF, 6'd63);
        send_req(ufifo_pkg::REQ_ENQ, 32'h0000_0000, 6'd0);     // duplicate
        send_req(ufifo_pkg::REQ_ENQ, 32'hFFFF_FFFF, 6'd0);     // duplicate
        send_req(ufifo_pkg::REQ_READ, 32'hFFFF_FFFF, 6'd1);
        send_req(ufifo_pkg::REQ_READ, 32'h0, 6'd0);
        send_req(ufifo_pkg::REQ_READ, 32'h0, 6'd2);            // past count
        send_req(ufifo_pkg::REQ_READ, 32'h0, 6'd63);
        send_req(REQ_UNUSED, 32'hFFFF_FFFF, 6'd63);            // ignored kind
        send_req(ufifo_pkg::REQ_ENQ, 32'hA5A5_A5A5, 6'd21);
        send_req(ufifo_pkg::REQ_ENQ, 32'h5A5A_5A5A, 6'd42);
        send_req(ufifo_pkg::REQ_DEQ, 32'h0, 6'd0);
        send_req(ufifo_pkg::REQ_DEQ, 32'h0, 6'd0);
        send_req(ufifo_pkg::REQ_ENQ, 32'h0000_0000, 6'd0);     // re-admitted after leaving
        send_req(ufifo_pkg::REQ_READ, 32'h0, 6'd2);
        send_req(ufifo_pkg::REQ_DEQ, 32'h0, 6'd0);
        send_req(ufifo_pkg::REQ_DEQ, 32'h0, 6'd0);
        send_req(ufifo_pkg::REQ_DEQ, 32'h0, 6'd0);
        send_req(ufifo_pkg::REQ_DEQ, 32'h0, 6'd0);             // empty again
        send_req(REQ_UNUSED, 32'h0, 6'd0);
        wait_all_replies();
    endtask

    // capacity left at its reset value: 64 fit, the next is refused
    task automatic test_reset_capacity();
        int i;
        for (i = 0; i <= DEPTH; i++)
            send_req(ufifo_pkg::REQ_ENQ, 32'h1000_0000 + i * 32'h0001_0003, 6'(i));
        send_req(ufifo_pkg::REQ_ENQ, 32'h1000_0000, 6'd0);     // duplicate while full
        send_req(ufifo_pkg::REQ_READ, 32'h0, 6'd63);
        wait_all_replies();
    endtask

    task automatic test_capacity_extremes();
        int i;
        write_capacity(7'd1);                       // already above the new limit
        send_req(ufifo_pkg::REQ_ENQ, 32'hDEAD_BEEF, 6'd0);
        send_req(ufifo_pkg::REQ_ENQ, 32'h1000_0000, 6'd0);
        write_capacity(7'd127);                     // clamps to depth
        send_req(ufifo_pkg::REQ_ENQ, 32'hDEAD_BEEF, 6'd0);
        send_req(ufifo_pkg::REQ_READ, 32'h0, 6'd63);
        for (i = 0; i < DEPTH; i++)
            send_req(ufifo_pkg::REQ_DEQ, 32'h0, 6'd0);
        send_req(ufifo_pkg::REQ_DEQ, 32'h0, 6'd0);
        write_capacity(7'd0);                       // every enqueue refused
        send_req(ufifo_pkg::REQ_ENQ, 32'h0000_0001, 6'd0);
        send_req(ufifo_pkg::REQ_READ, 32'h0, 6'd0);
        write_capacity(7'd1);
        send_req(ufifo_pkg::REQ_ENQ, 32'h8000_0000, 6'd0);
        send_req(ufifo_pkg::REQ_ENQ, 32'h7FFF_FFFF, 6'd0);     // full
        send_req(ufifo_pkg::REQ_ENQ, 32'h8000_0000, 6'd0);     // duplicate wins over full
        send_req(ufifo_pkg::REQ_DEQ, 32'h0, 6'd0);
        send_req(ufifo_pkg::REQ_ENQ, 32'h7FFF_FFFF, 6'd0);
        write_capacity(7'd2);
        send_req(ufifo_pkg::REQ_ENQ, 32'h8000_0000, 6'd0);
        send_req(ufifo_pkg::REQ_ENQ, 32'h1234_5678, 6'd0);
        send_req(ufifo_pkg::REQ_READ, 32'h0, 6'd1);
        send_req(ufifo_pkg::REQ_DEQ, 32'h0, 6'd0);
        send_req(ufifo_pkg::REQ_DEQ, 32'h0, 6'd0);
        wait_all_replies();
    endtask

    // sink stops for a long stretch while the source keeps offering beats
    task automatic test_output_backpressure();
        logic [ufifo_pkg::VALUE_W-1:0] pool[];
        int i;
        pool = new[8];
        for (i = 0; i < 8; i++)
            pool[i] = $urandom;
        write_capacity(7'd64);
        sink_hold_req = HOLD_CYCLES;
        for (i = 0; i < 40; i++)
            send_random_req(i < 30, pool);
        wait_all_replies();
    endtask

    task automatic test_random_traffic();
        logic [ufifo_pkg::VALUE_W-1:0] pool[];
        logic [6:0]                    caps[8];
        int                            phase;
        int                            n;
        int                            burst_left;
        bit                            fill_bias;
        caps = '{7'd64, 7'd3, 7'd1, 7'd17, 7'd64, 7'd40, 7'd127, 7'd0};
        caps[7] = 7'($urandom_range(1, 64));
        pool = new[POOL_SIZE];
        burst_left = 0;
        fill_bias = 1'b0;
        for (phase = 0; phase < 8; phase++)
        begin
            write_capacity(caps[phase]);
            foreach (pool[i])
                pool[i] = $urandom;
            src_gaps_on  = (phase != 2 && phase != 5);
            sink_gaps_on = (phase != 2 && phase != 5);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (burst_left == 0)
                begin
                    fill_bias = !fill_bias;
                    burst_left = $urandom_range(8, 40);
                end
                burst_left--;
                send_random_req(fill_bias, pool);
            end
        end
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        wait_all_replies();
    endtask

    // sink pacing; a long hold is counted out here
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (sink_hold_req != 0)
        begin
            sink_left = sink_hold_req;
            sink_hold_req = 0;
            m_axis_tready <= 1'b0;
        end
        else if (sink_left > 0)
        begin
            sink_left--;
            m_axis_tready <= 1'b0;
        end
        else if (sink_gaps_on && $urandom_range(0, 99) < 25)
        begin
            sink_left = pick_gap();
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : reply_check
        fifo_reply_t                    want;
        logic [ufifo_pkg::ITEM_W-1:0]   got_item;
        logic [ufifo_pkg::STATUS_W-1:0] got_status;
        logic [ufifo_pkg::COUNT_W-1:0]  got_count;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_item   = m_axis_tdata[31:0];
            got_status = m_axis_tdata[34:32];
            got_count  = m_axis_tdata[41:35];
            if (got_status <= ufifo_pkg::ST_RANGE)
                status_seen[got_status]++;
            if (pending_replies.size() == 0)
            begin
                $error("result beat with nothing outstanding: item %h status %0d count %0d",
                       got_item, got_status, got_count);
                mismatches++;
            end
            else
            begin
                want = pending_replies.pop_front();
                replies_checked++;
                if (got_item !== want.item)
                begin
                    $error("item_out: expected %h, got %h", want.item, got_item);
                    mismatches++;
                end
                if (got_status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got_status);
                    mismatches++;
                end
                if (got_count !== want.count)
                begin
                    $error("count: expected %0d, got %0d", want.count, got_count);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_basics();
        test_reset_capacity();
        test_capacity_extremes();
        test_output_backpressure();
        test_random_traffic();

        wait_all_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d requests, %0d results compared, capacities 0, 1, 2, 3, 17, 40, 64, 127",
                 requests_sent, replies_checked);
        $display("Statuses seen: ok %0d, duplicate %0d, full %0d, empty %0d, out of range %0d",
                 status_seen[ufifo_pkg::ST_OK], status_seen[ufifo_pkg::ST_DUP],
                 status_seen[ufifo_pkg::ST_FULL], status_seen[ufifo_pkg::ST_EMPTY],
                 status_seen[ufifo_pkg::ST_RANGE]);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
